// ===== hw/rtl/file_mode_string_parser_defines.svh =====
// Assertion macros used by the mode string parser top level.
`ifndef FILE_MODE_STRING_PARSER_DEFINES_SVH
`define FILE_MODE_STRING_PARSER_DEFINES_SVH

// Property checked on every rising clock edge outside reset.
`define FMSP_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every rising clock edge outside reset.
`define FMSP_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fmsp_pkg.sv =====
// Types and character codes for the mode string parser.
package fmsp_pkg;

   localparam int ModeW = 16;
   localparam int PermW = 9;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_7     = 8'h37;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_G     = 8'h67;
   localparam logic [7:0] CH_O     = 8'h6F;
   localparam logic [7:0] CH_A     = 8'h61;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_X     = 8'h78;

   // clause phase codes
   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_WHO   = 2'd1;
   localparam logic [1:0] PH_OP    = 2'd2;

   // operator codes
   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_ADD  = 2'd1;
   localparam logic [1:0] OP_SUB  = 2'd2;
   localparam logic [1:0] OP_SET  = 2'd3;

   // who bits
   localparam logic [2:0] WHO_U   = 3'b100;
   localparam logic [2:0] WHO_G   = 3'b010;
   localparam logic [2:0] WHO_O   = 3'b001;
   localparam logic [2:0] WHO_ALL = 3'b111;

   localparam logic [PermW-1:0] PERM_R = 9'o444;
   localparam logic [PermW-1:0] PERM_W = 9'o222;
   localparam logic [PermW-1:0] PERM_X = 9'o111;

   typedef struct packed {
      logic [7:0]       ch;
      logic             first;
      logic             last;
      logic [ModeW-1:0] file_mode;
   } fmsp_item_type;

   typedef struct packed {
      logic [ModeW-1:0] final_mode;
      logic             error;
      logic             was_octal;
   } fmsp_result_type;

   // symbolic parse state
   typedef struct packed {
      logic [1:0]       phase;
      logic [2:0]       who;
      logic [1:0]       op;
      logic [PermW-1:0] perm;
      logic [ModeW-1:0] work;
      logic             failed;
   } fmsp_clause_type;

endpackage

// ===== hw/rtl/fmsp_in_stage.sv =====
// Input register stage of the mode string parser.
module fmsp_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fmsp_pkg::fmsp_item_type req_item,
   input  logic                  advance,
   output logic                  item_valid,
   output fmsp_pkg::fmsp_item_type item
);
   import fmsp_pkg::*;

   logic          valid_ff;
   logic          valid_in;
   fmsp_item_type item_ff;
   logic          take;

   // stall only while the held item cannot move on this cycle
   assign req_stall  = valid_ff && !advance;
   assign take       = req_valid && !req_stall;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= req_item;
      end
   end

endmodule

// ===== hw/rtl/fmsp_core.sv =====
// Per-character parse step and parser state registers.
module fmsp_core #(
   parameter int MAX_OCTAL_DIGITS = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step_en,
   input  fmsp_pkg::fmsp_item_type   item,
   output fmsp_pkg::fmsp_result_type result
);
   import fmsp_pkg::*;

   localparam int OctW = 3 * MAX_OCTAL_DIGITS;
   localparam int CntW = $clog2(MAX_OCTAL_DIGITS + 1);

   fmsp_clause_type clause_ff, clause_in;
   logic [OctW-1:0] oct_ff, oct_in;
   logic [CntW-1:0] dcnt_ff, dcnt_in;
   logic            oct_ok_ff, oct_ok_in;

   function automatic logic [PermW-1:0] class_mask(input logic [2:0] who);
      logic [PermW-1:0] m;
      m = '0;
      if (who[2]) m = m | 9'o700;
      if (who[1]) m = m | 9'o070;
      if (who[0]) m = m | 9'o007;
      return m;
   endfunction

   function automatic fmsp_clause_type clear_clause(input fmsp_clause_type st);
      fmsp_clause_type r;
      r       = st;
      r.phase = PH_START;
      r.who   = '0;
      r.op    = OP_NONE;
      r.perm  = '0;
      return r;
   endfunction

   function automatic fmsp_clause_type close_clause(input fmsp_clause_type st);
      fmsp_clause_type r;
      r = st;
      if (st.phase == PH_WHO) begin
         // who letters with no operator
         r.failed = 1'b1;
      end else if (st.phase == PH_OP) begin
         case (st.op)
            OP_ADD: r.work = st.work | ModeW'(st.perm);
            OP_SUB: r.work = st.work & ~ModeW'(st.perm);
            OP_SET: r.work = (st.work & ~ModeW'(class_mask(st.who))) | ModeW'(st.perm);
            default: r.work = st.work;
         endcase
      end
      return clear_clause(r);
   endfunction

   function automatic fmsp_clause_type open_op(input fmsp_clause_type st,
                                               input logic [1:0] code);
      fmsp_clause_type r;
      r       = st;
      r.op    = code;
      r.who   = (st.who == '0) ? WHO_ALL : st.who;
      r.perm  = '0;
      r.phase = PH_OP;
      return r;
   endfunction

   fmsp_clause_type s;
   logic [OctW-1:0] oct_v;
   logic [CntW-1:0] dcnt_v;
   logic            oct_ok_v;
   logic            is_digit;

   assign is_digit = (item.ch >= CH_0) && (item.ch <= CH_7);

   always_comb begin
      // a first character restarts from the reset state with the sampled mode
      if (item.first) begin
         s        = '0;
         s.work   = item.file_mode;
         oct_v    = '0;
         dcnt_v   = '0;
         oct_ok_v = 1'b1;
      end else begin
         s        = clause_ff;
         oct_v    = oct_ff;
         dcnt_v   = dcnt_ff;
         oct_ok_v = oct_ok_ff;
      end

      if (oct_ok_v) begin
         if (is_digit && (dcnt_v < CntW'(MAX_OCTAL_DIGITS))) begin
            oct_v  = (oct_v << 3) | OctW'(item.ch[2:0]);
            dcnt_v = dcnt_v + CntW'(1);
         end else begin
            oct_ok_v = 1'b0;
         end
      end

      if (!s.failed) begin
         if (item.ch == CH_COMMA) begin
            s = close_clause(s);
         end else if (s.phase < PH_OP) begin
            case (item.ch)
               CH_U: begin s.who = s.who | WHO_U; s.phase = PH_WHO; end
               CH_G: begin s.who = s.who | WHO_G; s.phase = PH_WHO; end
               CH_O: begin s.who = s.who | WHO_O; s.phase = PH_WHO; end
               CH_A: begin s.who = WHO_ALL;       s.phase = PH_WHO; end
               CH_PLUS:  s = open_op(s, OP_ADD);
               CH_MINUS: s = open_op(s, OP_SUB);
               CH_EQ:    s = open_op(s, OP_SET);
               default:  s.failed = 1'b1;
            endcase
         end else begin
            case (item.ch)
               CH_R:    s.perm = s.perm | (PERM_R & class_mask(s.who));
               CH_W:    s.perm = s.perm | (PERM_W & class_mask(s.who));
               CH_X:    s.perm = s.perm | (PERM_X & class_mask(s.who));
               default: s.failed = 1'b1;
            endcase
         end
      end

      // end of string closes the open clause
      if (item.last && !s.failed) begin
         s = close_clause(s);
      end

      if (oct_ok_v && (dcnt_v != '0)) begin
         result.final_mode = ModeW'(oct_v);
         result.error      = 1'b0;
         result.was_octal  = 1'b1;
      end else if (s.failed) begin
         result.final_mode = '0;
         result.error      = 1'b1;
         result.was_octal  = 1'b0;
      end else begin
         result.final_mode = s.work;
         result.error      = 1'b0;
         result.was_octal  = 1'b0;
      end

      if (item.last) begin
         clause_in = '0;
         oct_in    = '0;
         dcnt_in   = '0;
         oct_ok_in = 1'b1;
      end else begin
         clause_in = s;
         oct_in    = oct_v;
         dcnt_in   = dcnt_v;
         oct_ok_in = oct_ok_v;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clause_ff <= '0;
         oct_ff    <= '0;
         dcnt_ff   <= '0;
         oct_ok_ff <= 1'b1;
      end else if (step_en) begin
         clause_ff <= clause_in;
         oct_ff    <= oct_in;
         dcnt_ff   <= dcnt_in;
         oct_ok_ff <= oct_ok_in;
      end
   end

endmodule

// ===== hw/rtl/file_mode_string_parser.sv =====
// Top level of the mode string parser: input stage, parse core, result register.
//
//   channel   direction  handshake         payload
//   req       in         req_valid/stall   ch, first, last, file_mode
//   rsp       out        rsp_valid/stall   final_mode, error, was_octal
//
// One character per cycle sustained while rsp_stall allows; the last character of a
// string passes the input register, then the core step, whose result is registered.
// Synchronous active-high reset clears all parser state and both valid flags.
// A held result with rsp_stall high stops the core; req_stall then rises
// once the input register is also occupied.
`include "file_mode_string_parser_defines.svh"

module file_mode_string_parser #(
   parameter int MAX_OCTAL_DIGITS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_ch,
   input  logic        req_first,
   input  logic        req_last,
   input  logic [15:0] req_file_mode,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_final_mode,
   output logic        rsp_error,
   output logic        rsp_was_octal
);
   import fmsp_pkg::*;

   localparam int OctW = 3 * MAX_OCTAL_DIGITS;

   fmsp_item_type   req_item;
   fmsp_item_type   item;
   logic            item_valid;
   logic            advance;
   fmsp_result_type step_result;
   fmsp_result_type rsp_ff;
   logic            rsp_valid_ff, rsp_valid_in;

   assign req_item.ch        = req_ch;
   assign req_item.first     = req_first;
   assign req_item.last      = req_last;
   assign req_item.file_mode = req_file_mode;

   // a character steps the core when the result register can take a transfer
   assign advance = item_valid && (!rsp_valid_ff || !rsp_stall);

   fmsp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   fmsp_core #(
      .MAX_OCTAL_DIGITS (MAX_OCTAL_DIGITS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item),
      .result  (step_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && item.last) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && item.last) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_final_mode = rsp_ff.final_mode;
   assign rsp_error      = rsp_ff.error;
   assign rsp_was_octal  = rsp_ff.was_octal;

   `FMSP_ASSERT(a_held_item_kept, clock, reset, (item_valid && !advance) |=> item_valid,
                "held character dropped")
   `FMSP_ASSERT_IMP(a_error_clean, clock, reset, rsp_valid && rsp_error,
                    (rsp_final_mode == '0) && !rsp_was_octal, "error result carries mode bits")
   `FMSP_ASSERT_IMP(a_octal_width, clock, reset, rsp_valid && rsp_was_octal,
                    (rsp_final_mode >> OctW) == '0 && !rsp_error,
                    "octal result exceeds digit width")
   `FMSP_ASSERT(a_no_result_without_last, clock, reset,
                (rsp_valid_ff && !rsp_stall && !(advance && item.last)) |=> !rsp_valid_ff,
                "result repeated")

endmodule

// ===== test/tb_file_mode_string_parser.sv =====
// Self-checking testbench for the mode string parser: directed strings, then random strings.
`timescale 1ns / 100ps

module tb_file_mode_string_parser;
   import fmsp_pkg::*;

   localparam int MaxDigits  = 4;
   localparam int LongHold   = 300;
   localparam int CycleLimit = 400000;

   localparam fmsp_result_type BadString = '{final_mode: '0, error: 1'b1, was_octal: 1'b0};

   typedef struct {
      fmsp_item_type   it;
      bit              typed;
      fmsp_result_type res;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_ch;
   logic        req_first;
   logic        req_last;
   logic [15:0] req_file_mode;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_final_mode;
   logic        rsp_error;
   logic        rsp_was_octal;

   // mode-string predictor state
   logic [1:0]       pr_phase;
   logic [2:0]       pr_who;
   logic [1:0]       pr_op;
   logic [PermW-1:0] pr_perm;
   logic [ModeW-1:0] pr_mode;
   logic [11:0]      pr_octal;
   logic [2:0]       pr_digits;
   logic             pr_octal_ok;
   logic             pr_failed;

   fmsp_result_type expected_modes[$];
   fmsp_result_type want;
   dir_row_type     dir_rows[$];
   logic [7:0]      line_chars[$];

   int  send_gap_pct;
   int  recv_gap_pct;
   bit  long_hold_req = 1'b0;
   bit  hold_done = 1'b0;
   int  hold_count;
   int  error_count = 0;
   int  chars_sent;
   int  cycle_count = 0;
   int  octal_seen = 0;
   int  symbolic_seen = 0;
   int  error_seen = 0;

   file_mode_string_parser #(
      .MAX_OCTAL_DIGITS(MaxDigits)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_ch        (req_ch),
      .req_first     (req_first),
      .req_last      (req_last),
      .req_file_mode (req_file_mode),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_final_mode(rsp_final_mode),
      .rsp_error     (rsp_error),
      .rsp_was_octal (rsp_was_octal)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [PermW-1:0] class_bits(input logic [2:0] who);
      logic [PermW-1:0] m;
      m = '0;
      if ((who & WHO_U) != 0) m |= 9'o700;
      if ((who & WHO_G) != 0) m |= 9'o070;
      if ((who & WHO_O) != 0) m |= 9'o007;
      return m;
   endfunction

   task automatic open_clause();
      pr_phase = PH_START;
      pr_who   = '0;
      pr_op    = OP_NONE;
      pr_perm  = '0;
   endtask

   task automatic restart_parse();
      open_clause();
      pr_mode     = '0;
      pr_octal    = '0;
      pr_digits   = '0;
      pr_octal_ok = 1'b1;
      pr_failed   = 1'b0;
   endtask

   // apply the open clause to the working mode
   task automatic finish_clause();
      if (pr_phase == PH_WHO) begin
         pr_failed = 1'b1;
      end else if (pr_phase == PH_OP) begin
         case (pr_op)
            OP_ADD: pr_mode = pr_mode | {7'b0, pr_perm};
            OP_SUB: pr_mode = pr_mode & ~{7'b0, pr_perm};
            OP_SET: pr_mode = (pr_mode & ~{7'b0, class_bits(pr_who)}) | {7'b0, pr_perm};
            default: ;
         endcase
      end
      open_clause();
   endtask

   task automatic mode_parse_step(input fmsp_item_type it, output bit got,
                                  output fmsp_result_type res);
      logic [PermW-1:0] m;
      res = '0;
      if (it.first) begin
         restart_parse();
         pr_mode = it.file_mode;
      end
      if (pr_octal_ok) begin
         if (it.ch >= CH_0 && it.ch <= CH_7 && pr_digits < MaxDigits) begin
            pr_octal  = {pr_octal[8:0], it.ch[2:0]};
            pr_digits = pr_digits + 3'd1;
         end else begin
            pr_octal_ok = 1'b0;
         end
      end
      if (!pr_failed) begin
         if (it.ch == CH_COMMA) begin
            finish_clause();
         end else if (pr_phase != PH_OP) begin
            case (it.ch)
               CH_U: begin pr_who |= WHO_U; pr_phase = PH_WHO; end
               CH_G: begin pr_who |= WHO_G; pr_phase = PH_WHO; end
               CH_O: begin pr_who |= WHO_O; pr_phase = PH_WHO; end
               CH_A: begin pr_who |= WHO_ALL; pr_phase = PH_WHO; end
               CH_PLUS, CH_MINUS, CH_EQ: begin
                  pr_op = (it.ch == CH_PLUS) ? OP_ADD : (it.ch == CH_MINUS) ? OP_SUB : OP_SET;
                  if (pr_who == 3'b000) pr_who = WHO_ALL;
                  pr_perm  = '0;
                  pr_phase = PH_OP;
               end
               default: pr_failed = 1'b1;
            endcase
         end else begin
            m = class_bits(pr_who);
            case (it.ch)
               CH_R: pr_perm |= PERM_R & m;
               CH_W: pr_perm |= PERM_W & m;
               CH_X: pr_perm |= PERM_X & m;
               default: pr_failed = 1'b1;
            endcase
         end
      end
      got = it.last;
      if (it.last) begin
         if (!pr_failed) finish_clause();
         if (pr_octal_ok && pr_digits > 0)
            res = '{final_mode: {4'b0, pr_octal}, error: 1'b0, was_octal: 1'b1};
         else if (pr_failed)
            res = BadString;
         else
            res = '{final_mode: pr_mode, error: 1'b0, was_octal: 1'b0};
         restart_parse();
      end
   endtask

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input fmsp_item_type it, input bit typed,
                            input fmsp_result_type typed_res);
      bit              got;
      fmsp_result_type res;
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_ch        <= it.ch;
      req_first     <= it.first;
      req_last      <= it.last;
      req_file_mode <= it.file_mode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      mode_parse_step(it, got, res);
      if (got) expected_modes.push_back(typed ? typed_res : res);
      chars_sent++;
      @(negedge clock);
   endtask

   task automatic table_string(input string s, input bit with_first, input logic [15:0] cur,
                               input bit typed, input fmsp_result_type res);
      dir_row_type row;
      for (int i = 0; i < s.len(); i++) begin
         row.it    = '{ch: s[i], first: with_first && i == 0, last: i == s.len() - 1,
                       file_mode: cur};
         row.typed = typed && row.it.last;
         row.res   = res;
         dir_rows.push_back(row);
      end
   endtask

   // fills line_chars with one mode string; noisy strings get odd flags too
   task automatic make_line(output bit noisy);
      string who_pool;
      string op_pool;
      string perm_pool;
      string junk_pool;
      int    kind;
      int    n;
      bit    drop_op;
      who_pool  = "ugoa";
      op_pool   = "+-=";
      perm_pool = "rwx";
      junk_pool = "ugoa+-=rwx,01789";
      line_chars.delete();
      noisy = 1'b0;
      kind  = $urandom_range(99);
      if (kind < 30) begin
         n = ($urandom_range(9) == 0) ? MaxDigits + 1 : $urandom_range(1, MaxDigits);
         for (int i = 0; i < n; i++) line_chars.push_back(8'(CH_0 + $urandom_range(7)));
      end else if (kind < 85) begin
         drop_op = ($urandom_range(19) == 0);
         n = $urandom_range(1, 3);
         for (int c = 0; c < n; c++) begin
            if (c > 0) line_chars.push_back(CH_COMMA);
            if ($urandom_range(9) == 0) continue;
            repeat ($urandom_range(0, 3))
               line_chars.push_back(who_pool[$urandom_range(who_pool.len() - 1)]);
            if (!drop_op) line_chars.push_back(op_pool[$urandom_range(op_pool.len() - 1)]);
            repeat ($urandom_range(0, 3))
               line_chars.push_back(perm_pool[$urandom_range(perm_pool.len() - 1)]);
         end
         if ($urandom_range(19) == 0) line_chars.push_back(CH_COMMA);
         if (line_chars.size() == 0) line_chars.push_back(CH_COMMA);
         if ($urandom_range(19) == 0)
            line_chars[$urandom_range(line_chars.size() - 1)] = 8'($urandom_range(255));
      end else begin
         noisy = 1'b1;
         repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(1) == 0)
               line_chars.push_back(8'($urandom_range(255)));
            else
               line_chars.push_back(junk_pool[$urandom_range(junk_pool.len() - 1)]);
         end
      end
   endtask

   task automatic run_random(input int count);
      fmsp_item_type it;
      bit            noisy;
      int            start;
      start = chars_sent;
      while (chars_sent - start < count) begin
         make_line(noisy);
         for (int i = 0; i < line_chars.size(); i++) begin
            it.ch    = line_chars[i];
            it.first = (i == 0) ? ($urandom_range(99) < 95) : (noisy && $urandom_range(99) < 8);
            it.last  = (i == line_chars.size() - 1) || (noisy && $urandom_range(99) < 5);
            case ($urandom_range(9))
               0: it.file_mode = 16'h0000;
               1: it.file_mode = 16'hFFFF;
               default: it.file_mode = 16'($urandom);
            endcase
            send_item(it, 1'b0, '0);
         end
      end
   endtask

   // hold the sender until every expected result has come back
   task automatic settle();
      req_valid <= 1'b0;
      wait (expected_modes.size() == 0);
      @(negedge clock);
   endtask

   // receiver: random stall, plus one long hold when asked
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_req && !hold_done) begin
            rsp_stall <= 1'b1;
            for (hold_count = 0; hold_count < LongHold; hold_count++) @(negedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= ($urandom_range(99) < recv_gap_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_modes.size() == 0) begin
            $display("%0t: result with nothing expected: final_mode=%h error=%b was_octal=%b",
                     $time, rsp_final_mode, rsp_error, rsp_was_octal);
            error_count++;
         end else begin
            want = expected_modes.pop_front();
            if (rsp_final_mode !== want.final_mode) begin
               $display("%0t: final_mode expected %h actual %h", $time, want.final_mode,
                        rsp_final_mode);
               error_count++;
            end
            if (rsp_error !== want.error) begin
               $display("%0t: error expected %b actual %b", $time, want.error, rsp_error);
               error_count++;
            end
            if (rsp_was_octal !== want.was_octal) begin
               $display("%0t: was_octal expected %b actual %b", $time, want.was_octal,
                        rsp_was_octal);
               error_count++;
            end
         end
         if (rsp_error) error_seen++;
         else if (rsp_was_octal) octal_seen++;
         else symbolic_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_modes.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      dir_row_type row;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_ch        = '0;
      req_first     = 1'b0;
      req_last      = 1'b0;
      req_file_mode = '0;
      send_gap_pct  = 32;
      recv_gap_pct  = 78;
      chars_sent    = 0;
      restart_parse();

      // directed strings: octal extremes, each operator and who letter, empty clause,
      // missing operator, NUL code, too many digits, a string with no first flag
      table_string("7", 1'b1, 16'h0000, 1'b1, '{final_mode: 16'o7, error: 1'b0, was_octal: 1'b1});
      table_string("7777", 1'b1, 16'hFFFF, 1'b1,
                   '{final_mode: 16'o7777, error: 1'b0, was_octal: 1'b1});
      table_string("ao+x", 1'b1, 16'h0000, 1'b0, '0);
      table_string("g=r,,-w", 1'b1, 16'hFFFF, 1'b0, '0);
      table_string("u,", 1'b1, 16'o755, 1'b1, BadString);
      row.it    = '{ch: 8'h00, first: 1'b1, last: 1'b1, file_mode: 16'hFFFF};
      row.typed = 1'b1;
      row.res   = BadString;
      dir_rows.push_back(row);
      table_string("77777", 1'b1, 16'h0000, 1'b1, BadString);
      table_string("x", 1'b0, 16'hFFFF, 1'b1, BadString);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) send_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);
      run_random(330);
      settle();

      send_gap_pct = 78;
      recv_gap_pct = 32;
      run_random(340);
      settle();

      // no idling; the long receiver hold backs up the input meanwhile
      send_gap_pct  = 0;
      recv_gap_pct  = 0;
      long_hold_req = 1'b1;
      run_random(355);
      settle();
      repeat (8) @(posedge clock);

      $display("Sent %0d characters; checked %0d octal, %0d symbolic and %0d error results",
               chars_sent, octal_seen, symbolic_seen, error_seen);
      $display("Idle mixes: sender-light, receiver-light and none, with one long output hold");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
